// ===== sv/swlrl_pkg.sv =====
package swlrl_pkg;

    // fixed field widths of the request, result and configuration channels
    localparam int CLIENT_W   = 6;
    localparam int TIME_W     = 32;
    localparam int LIMIT_W    = 5;
    localparam int REMAIN_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // default sizing of the client table and the per-client log
    localparam int NUM_CLIENTS_DEF = 64;
    localparam int MAX_LIMIT_DEF   = 16;

    // depth of the queue between front and back
    localparam int FIFO_DEPTH = 2;

    // configuration reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 5'd16;
    localparam logic [TIME_W-1:0]  WINDOW_RESET = 32'd1000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REQUEST_LIMIT = 1'b0,
        REG_WINDOW_TICKS  = 1'b1
    } cfg_reg_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_META,
        ST_STAMP,
        ST_DECIDE
    } back_state_t;

    // request as held in the queue, client index already wrapped
    typedef struct packed {
        logic [CLIENT_W-1:0] client;
        logic [TIME_W-1:0]   stamp;
    } item_t;

endpackage

// ===== sv/swlrl_req_if.sv =====
interface swlrl_req_if;
    import swlrl_pkg::*;

    logic                valid;
    logic                ready;
    logic [CLIENT_W-1:0] client_index;
    logic [TIME_W-1:0]   now;

    modport source (output valid, output client_index, output now, input ready);
    modport sink   (input valid, input client_index, input now, output ready);
endinterface

// ===== sv/swlrl_rsp_if.sv =====
interface swlrl_rsp_if;
    import swlrl_pkg::*;

    logic                valid;
    logic                ready;
    logic                allowed;
    logic [REMAIN_W-1:0] remaining;
    logic [TIME_W-1:0]   retry_after;

    modport source (output valid, output allowed, output remaining, output retry_after,
                    input ready);
    modport sink   (input valid, input allowed, input remaining, input retry_after,
                    output ready);
endinterface

// ===== sv/swlrl_cfg_if.sv =====
interface swlrl_cfg_if;
    import swlrl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/swlrl_front.sv =====
module swlrl_front #(
    parameter int NUM_CLIENTS = swlrl_pkg::NUM_CLIENTS_DEF
) (
    swlrl_req_if.sink         req,
    input  logic              q_full,
    output logic              q_push,
    output swlrl_pkg::item_t  q_item
);
    import swlrl_pkg::*;

    localparam int IDX_SPAN = 2 ** CLIENT_W;

    logic [CLIENT_W-1:0] wrap_tab [IDX_SPAN];

    // client index wrap table, built at elaboration
    generate
        for (genvar i = 0; i < IDX_SPAN; i++)
        begin : g_wrap
            localparam int WRAPPED = i % NUM_CLIENTS;
            assign wrap_tab[i] = CLIENT_W'(WRAPPED);
        end
    endgenerate

    // take a request whenever the queue has room
    assign req.ready     = !q_full;
    assign q_push        = req.valid && !q_full;
    assign q_item.client = wrap_tab[req.client_index];
    assign q_item.stamp  = req.now;

endmodule

// ===== sv/swlrl_fifo.sv =====
module swlrl_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  swlrl_pkg::item_t  push_item,
    output logic              full,
    input  logic              pop,
    output swlrl_pkg::item_t  pop_item,
    output logic              empty
);
    import swlrl_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    item_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    assign full     = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/swlrl_back.sv =====
module swlrl_back #(
    parameter int NUM_CLIENTS = swlrl_pkg::NUM_CLIENTS_DEF,
    parameter int MAX_LIMIT   = swlrl_pkg::MAX_LIMIT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  swlrl_pkg::item_t                q_item,
    output logic                            q_pop,
    input  logic [swlrl_pkg::LIMIT_W-1:0]   limit,
    input  logic [swlrl_pkg::TIME_W-1:0]    window,
    swlrl_rsp_if.source                     rsp
);
    import swlrl_pkg::*;

    localparam int CW    = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int SW    = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;
    localparam int NW    = $clog2(MAX_LIMIT + 1);
    localparam int TW    = NW + 1;
    localparam int DEPTH = NUM_CLIENTS * MAX_LIMIT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        logic [SW-1:0] head;
        logic [NW-1:0] count;
    } meta_t;

    back_state_t          state_reg;
    back_state_t          state_next;
    item_t                item_reg;
    item_t                item_next;
    logic [SW-1:0]        head_reg;
    logic [SW-1:0]        head_next;
    logic [NW-1:0]        count_reg;
    logic [NW-1:0]        count_next;
    logic [TIME_W-1:0]    oldest_reg;
    logic [TIME_W-1:0]    oldest_next;

    // per-client head and count, with a valid bit per client
    meta_t                meta_mem [NUM_CLIENTS];
    meta_t                meta_rd_reg;
    meta_t                meta_wdata;
    logic [NUM_CLIENTS-1:0] meta_vld_reg;
    logic                 meta_hit_reg;
    logic                 meta_re;
    logic                 meta_we;
    logic [CW-1:0]        meta_raddr;

    // timestamp log, one row of slots per client
    logic [TIME_W-1:0]    stamp_mem [DEPTH];
    logic [TIME_W-1:0]    stamp_rd_reg;
    logic                 stamp_re;
    logic                 stamp_we;
    logic [AW-1:0]        stamp_raddr;
    logic [AW-1:0]        stamp_waddr;

    // result register
    logic                 out_valid_reg;
    logic                 out_allowed_reg;
    logic                 out_allowed_next;
    logic [REMAIN_W-1:0]  out_remaining_reg;
    logic [REMAIN_W-1:0]  out_remaining_next;
    logic [TIME_W-1:0]    out_retry_reg;
    logic [TIME_W-1:0]    out_retry_next;
    logic                 out_load;
    logic                 out_free;

    logic [CW-1:0]        client;
    logic [NW-1:0]        eff_limit;
    logic [TIME_W-1:0]    age;
    logic                 expired;
    logic [TIME_W-1:0]    wait_ticks;
    logic [SW-1:0]        head_inc;
    logic [TW-1:0]        tail_sum;
    logic [SW-1:0]        tail_slot;
    logic                 refuse;

    assign client = CW'(item_reg.client);

    // limit of zero acts as one, above the log depth acts as the depth
    always_comb
    begin
        if (limit == '0)
        begin
            eff_limit = NW'(1);
        end
        else if (32'(limit) > 32'(MAX_LIMIT))
        begin
            eff_limit = NW'(MAX_LIMIT);
        end
        else
        begin
            eff_limit = NW'(limit);
        end
    end

    // age of the entry just read, and ticks until the oldest one expires
    assign age        = item_reg.stamp - stamp_rd_reg;
    assign expired    = (age >= window);
    assign wait_ticks = oldest_reg + window - item_reg.stamp;

    // ring arithmetic on slot numbers
    assign head_inc  = (head_reg == SW'(MAX_LIMIT - 1)) ? '0 : head_reg + SW'(1);
    assign tail_sum  = TW'(head_reg) + TW'(count_reg);
    assign tail_slot = (tail_sum >= TW'(MAX_LIMIT)) ? SW'(tail_sum - TW'(MAX_LIMIT))
                                                     : SW'(tail_sum);

    assign refuse     = (count_reg >= eff_limit);
    assign out_free   = !out_valid_reg || rsp.ready;

    // expired entries stay dropped on refusal, the new entry is counted on acceptance
    assign meta_wdata = '{head: head_reg, count: refuse ? count_reg : count_reg + NW'(1)};

    assign stamp_raddr = AW'(AW'(client) * AW'(MAX_LIMIT) + AW'(head_next));
    assign stamp_waddr = AW'(AW'(client) * AW'(MAX_LIMIT) + AW'(tail_slot));

    // sequencer: fetch client state, drop expired entries, then decide
    always_comb
    begin
        state_next         = state_reg;
        item_next          = item_reg;
        head_next          = head_reg;
        count_next         = count_reg;
        oldest_next        = oldest_reg;
        q_pop              = 1'b0;
        meta_re            = 1'b0;
        meta_we            = 1'b0;
        meta_raddr         = CW'(q_item.client);
        stamp_re           = 1'b0;
        stamp_we           = 1'b0;
        out_load           = 1'b0;
        out_allowed_next   = 1'b0;
        out_remaining_next = '0;
        out_retry_next     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    meta_re    = 1'b1;
                    state_next = ST_META;
                end
            end
            ST_META:
            begin
                if (meta_hit_reg)
                begin
                    head_next  = meta_rd_reg.head;
                    count_next = meta_rd_reg.count;
                end
                else
                begin
                    head_next  = '0;
                    count_next = '0;
                end
                if (count_next == '0)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    stamp_re   = 1'b1;
                    state_next = ST_STAMP;
                end
            end
            ST_STAMP:
            begin
                if (expired)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - NW'(1);
                    if (count_next == '0)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        stamp_re = 1'b1;
                    end
                end
                else
                begin
                    oldest_next = stamp_rd_reg;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    meta_we    = 1'b1;
                    state_next = ST_IDLE;
                    if (refuse)
                    begin
                        out_retry_next = wait_ticks;
                    end
                    else
                    begin
                        stamp_we           = 1'b1;
                        out_allowed_next   = 1'b1;
                        out_remaining_next = REMAIN_W'(eff_limit - count_reg - NW'(1));
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            meta_vld_reg  <= '0;
            meta_hit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (meta_we)
            begin
                meta_vld_reg[client] <= 1'b1;
            end
            if (meta_re)
            begin
                meta_hit_reg <= meta_vld_reg[meta_raddr];
            end
        end
    end

    // working registers of the current request
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        head_reg   <= head_next;
        count_reg  <= count_next;
        oldest_reg <= oldest_next;
        if (out_load)
        begin
            out_allowed_reg   <= out_allowed_next;
            out_remaining_reg <= out_remaining_next;
            out_retry_reg     <= out_retry_next;
        end
    end

    // client state memory
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[client] <= meta_wdata;
        end
        if (meta_re)
        begin
            meta_rd_reg <= meta_mem[meta_raddr];
        end
    end

    // timestamp log memory
    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= item_reg.stamp;
        end
        if (stamp_re)
        begin
            stamp_rd_reg <= stamp_mem[stamp_raddr];
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.allowed     = out_allowed_reg;
    assign rsp.remaining   = out_remaining_reg;
    assign rsp.retry_after = out_retry_reg;

endmodule

// ===== sv/sliding_window_log_rate_limiter_core.sv =====
// path: a transferred request is queued; the back sequencer then reads the client state,
//   walks the client log from its oldest entry through the single timestamp memory read
//   port, dropping expired entries until one is kept or the log is empty, and decides once
//   the result register is free; it finishes one request before it takes the next
// reset: queue, sequencer and result register cleared, every client log empty through its
//   valid bit, request_limit 16, window_ticks 1000; timestamp memory is not cleared
module sliding_window_log_rate_limiter_core #(
    parameter int NUM_CLIENTS = swlrl_pkg::NUM_CLIENTS_DEF,
    parameter int MAX_LIMIT   = swlrl_pkg::MAX_LIMIT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    swlrl_req_if.sink    req,
    swlrl_rsp_if.source  rsp,
    swlrl_cfg_if.sink    cfg
);
    import swlrl_pkg::*;

    logic                 q_push;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    item_t                push_item;
    item_t                pop_item;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [TIME_W-1:0]    window_reg;

    // configuration registers, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= LIMIT_RESET;
            window_reg <= WINDOW_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_REQUEST_LIMIT: limit_reg  <= cfg.data[LIMIT_W-1:0];
                REG_WINDOW_TICKS:  window_reg <= cfg.data[TIME_W-1:0];
                default:           ;
            endcase
        end
    end

    // request intake
    swlrl_front #(
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (push_item)
    );

    // queue between intake and log processing
    swlrl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    // log processing and result register
    swlrl_back #(
        .NUM_CLIENTS (NUM_CLIENTS),
        .MAX_LIMIT   (MAX_LIMIT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (pop_item),
        .q_pop   (q_pop),
        .limit   (limit_reg),
        .window  (window_reg),
        .rsp     (rsp)
    );

`ifndef SYNTH
    // no push into a full queue
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    // no pop from an empty queue
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // a request transfer leaves the queue holding at least one item
    a_transfer_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !q_empty)
        else $error("request transfer lost before queue");
`endif

endmodule
